>>> src/ppid_pkg.sv
// shared constants, types and fixed-point helpers for the positional pid block
// no dependencies; imported by ppid_mul, ppid_div and positional_pid_antiwindup
package ppid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LIM_W      = DATA_WIDTH - 1;
    localparam int MAG_W      = DATA_WIDTH + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int DIV_W      = 2 * DATA_WIDTH;
    localparam int SUM_W      = DATA_WIDTH + 2;
    localparam int MUL_CNT_W  = $clog2(MAG_W + 1);
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [MAG_W-1:0]      wide_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [LIM_W-1:0]             ulim_t;
    typedef logic [MAG_W-1:0]             mag_t;
    typedef logic [PROD_W-1:0]            prod_t;
    typedef logic [DIV_W-1:0]             quot_t;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = CFG_IDX_W'(6);

    localparam ulim_t TIME_STEP_RESET = ulim_t'(1) << FRAC_BITS;
    localparam ulim_t LIMIT_RESET     = '1;
    localparam word_t WORD_MAX        = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN        = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // magnitude of a sign-extended value
    function automatic mag_t mag_of(input wide_t v);
        mag_t r;
        r = v[MAG_W-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
        return r;
    endfunction

    // signed result from magnitude and sign, floor toward minus infinity, saturated
    function automatic word_t sat_finish(input prod_t m, input logic neg, input logic bump);
        prod_t m1;
        prod_t pos_max;
        word_t r;
        pos_max = (prod_t'(1) << (DATA_WIDTH - 1)) - prod_t'(1);
        m1 = m + prod_t'(neg & bump);
        if (neg)
        begin
            if (m1 > pos_max + prod_t'(1))
                r = WORD_MIN;
            else
                r = word_t'(~m1[DATA_WIDTH-1:0] + 1'b1);
        end
        else
        begin
            if (m1 > pos_max)
                r = WORD_MAX;
            else
                r = word_t'(m1[DATA_WIDTH-1:0]);
        end
        return r;
    endfunction

    // clamp to plus or minus lim
    function automatic word_t clamp_sym(input sum_t v, input ulim_t lim);
        sum_t hi;
        sum_t lo;
        word_t r;
        hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi)
            r = hi[DATA_WIDTH-1:0];
        else if (v < lo)
            r = lo[DATA_WIDTH-1:0];
        else
            r = v[DATA_WIDTH-1:0];
        return r;
    endfunction

endpackage

>>> src/ppid_mul.sv
// bit-serial shift-add multiplier for unsigned magnitudes, one multiplier bit per cycle
// depends on ppid_pkg
module ppid_mul
    import ppid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  mag_t  a,
    input  mag_t  b,
    output logic  done,
    output prod_t prod
);

    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    mag_t                 mcand_reg, mcand_next;
    mag_t                 mplier_reg, mplier_next;
    prod_t                acc_reg, acc_next;
    logic [MAG_W:0]       sum;

    always_comb
    begin
        sum         = {1'b0, acc_reg[PROD_W-1:MAG_W]}
                    + {1'b0, (mplier_reg[0] ? mcand_reg : '0)};
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            mcand_next  = a;
            mplier_next = b;
            acc_next    = '0;
            cnt_next    = '0;
            run_next    = 1'b1;
        end
        else if (run_reg)
        begin
            // add into the upper half, then shift the whole product right
            acc_next    = {sum, acc_reg[MAG_W-1:1]};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MAG_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> src/ppid_div.sv
// restoring radix-2 divider, one quotient bit per cycle, divisor must be nonzero
// depends on ppid_pkg
module ppid_div
    import ppid_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  quot_t dividend,
    input  ulim_t divisor,
    output logic  done,
    output quot_t quot,
    output logic  rem_nz
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    quot_t                q_reg, q_next;
    ulim_t                rem_reg, rem_next;
    ulim_t                dvs_reg, dvs_next;
    logic [LIM_W:0]       trial;
    logic [LIM_W:0]       trial_sub;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            rem_next = ge ? trial_sub[LIM_W-1:0] : trial[LIM_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done   = done_reg;
    assign quot   = q_reg;
    assign rem_nz = |rem_reg;

endmodule

>>> src/positional_pid_antiwindup.sv
// positional pid controller with dead band, integral clamp and output clamp
// input stream: one transfer carries setpoint and measured value; output stream:
// one transfer per input carries the drive value and the dead band flag in tuser.
// gains and limits are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, the block itself does not enforce it. when the error
// falls within the dead band, the check state goes straight to the output state.
// the next input is taken only once a result is registered and the state is idle;
// the derivative term's 64-step divider dominates, after a 33-step multiplier pass.
// the three first-stage products run side by side on three bit-serial multipliers;
// the integral scaling by the time step reuses the integral multiplier while the
// division runs.
// the result sits in an output register, so a new input is taken while the
// receiver stalls; if the previous result is still held when the next one is
// ready, the controller waits in its last state until the register frees.
// reset clears previous error and integral, loads time step 1.0, dead band 0,
// limits to all ones and gains to zero.
// depends on ppid_pkg, ppid_mul, ppid_div
module positional_pid_antiwindup
    import ppid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*DATA_WIDTH-1:0] s_tdata,   // setpoint, measured
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_WIDTH-1:0]   m_tdata,   // drive
    output logic                    m_tuser,   // in_deadband
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_WIDTH-1:0]   cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_START  = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_START2 = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_INT    = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;

    // configuration
    word_t prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    ulim_t time_step_reg, dead_band_reg, integ_limit_reg, out_limit_reg;

    logic [3:0] state_reg, state_next;
    word_t      prev_reg, prev_next;
    word_t      integ_reg, integ_next;
    word_t      err_reg, err_next;
    word_t      old_reg, old_next;
    wide_t      diff_reg, diff_next;
    logic       dead_reg, dead_next;
    logic       neg_i_reg, neg_i_next;
    logic       neg_p_reg, neg_p_next;
    logic       neg_d_reg, neg_d_next;
    logic       neg_t_reg, neg_t_next;
    word_t      t1_reg, t1_next;
    word_t      p_reg, p_next;
    word_t      t2_reg, t2_next;
    word_t      d_reg, d_next;
    logic       out_valid_reg, out_valid_next;
    word_t      out_data_reg, out_data_next;
    logic       out_flag_reg, out_flag_next;

    word_t               sp;
    word_t               ms;
    logic [DATA_WIDTH:0] in_diff;
    word_t               err_in;
    logic                in_xfer;
    logic                out_free;
    mag_t                err_mag;

    logic  mul_i_start, mul_pd_start;
    mag_t  mul_i_a, mul_i_b;
    logic  mul_i_done, mul_p_done, mul_d_done;
    prod_t prod_i, prod_p, prod_d;
    logic  div_start, div_done, div_rem_nz;
    ulim_t div_dvs;
    quot_t div_quot;

    assign sp       = s_tdata[DATA_WIDTH-1:0];
    assign ms       = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_diff  = {sp[DATA_WIDTH-1], sp} - {ms[DATA_WIDTH-1], ms};
    assign err_in   = (in_diff[DATA_WIDTH] != in_diff[DATA_WIDTH-1])
                    ? (in_diff[DATA_WIDTH] ? WORD_MIN : WORD_MAX)
                    : word_t'(in_diff[DATA_WIDTH-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign err_mag  = mag_of(wide_t'(err_reg));

    // multiplier operands: first pass ki*err, second pass t1*time_step
    assign mul_pd_start = (state_reg == ST_START);
    assign mul_i_start  = (state_reg == ST_START) || (state_reg == ST_START2);
    assign mul_i_a      = (state_reg == ST_START2) ? mag_of(wide_t'(t1_reg))
                                                   : mag_of(wide_t'(integ_gain_reg));
    assign mul_i_b      = (state_reg == ST_START2) ? mag_t'(time_step_reg) : err_mag;
    assign div_start    = (state_reg == ST_START2);
    assign div_dvs      = (time_step_reg == '0) ? ulim_t'(1) : time_step_reg;

    ppid_mul u_mul_i (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_i_start),
        .a     (mul_i_a),
        .b     (mul_i_b),
        .done  (mul_i_done),
        .prod  (prod_i)
    );

    ppid_mul u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_pd_start),
        .a     (mag_of(wide_t'(prop_gain_reg))),
        .b     (err_mag),
        .done  (mul_p_done),
        .prod  (prod_p)
    );

    ppid_mul u_mul_d (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_pd_start),
        .a     (mag_of(wide_t'(deriv_gain_reg))),
        .b     (mag_of(diff_reg)),
        .done  (mul_d_done),
        .prod  (prod_d)
    );

    ppid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_d[DIV_W-1:0]),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz)
    );

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        err_next       = err_reg;
        old_next       = old_reg;
        diff_next      = diff_reg;
        dead_next      = dead_reg;
        neg_i_next     = neg_i_reg;
        neg_p_next     = neg_p_reg;
        neg_d_next     = neg_d_reg;
        neg_t_next     = neg_t_reg;
        t1_next        = t1_reg;
        p_next         = p_reg;
        t2_next        = t2_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next   = err_in;
                    old_next   = prev_reg;
                    prev_next  = err_in;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                dead_next  = err_mag <= mag_t'(dead_band_reg);
                diff_next  = wide_t'(err_reg) - wide_t'(old_reg);
                neg_i_next = integ_gain_reg[DATA_WIDTH-1] ^ err_reg[DATA_WIDTH-1];
                neg_p_next = prop_gain_reg[DATA_WIDTH-1] ^ err_reg[DATA_WIDTH-1];
                state_next = (err_mag <= mag_t'(dead_band_reg)) ? ST_OUT : ST_START;
            end
            ST_START:
            begin
                neg_d_next = deriv_gain_reg[DATA_WIDTH-1] ^ diff_reg[MAG_W-1];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // the three multipliers run in lockstep
                if (mul_i_done && mul_p_done && mul_d_done)
                begin
                    t1_next    = sat_finish(prod_i >> FRAC_BITS, neg_i_reg,
                                            |prod_i[FRAC_BITS-1:0]);
                    p_next     = sat_finish(prod_p >> FRAC_BITS, neg_p_reg,
                                            |prod_p[FRAC_BITS-1:0]);
                    state_next = ST_START2;
                end
            end
            ST_START2:
            begin
                neg_t_next = t1_reg[DATA_WIDTH-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // the time step product finishes well before the quotient
                if (div_done)
                begin
                    t2_next    = sat_finish(prod_i >> FRAC_BITS, neg_t_reg,
                                            |prod_i[FRAC_BITS-1:0]);
                    d_next     = sat_finish(prod_t'(div_quot), neg_d_reg, div_rem_nz);
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                integ_next = clamp_sym(sum_t'(integ_reg) + sum_t'(t2_reg), integ_limit_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = dead_reg;
                    out_data_next  = dead_reg ? word_t'(0)
                                   : clamp_sym(sum_t'(p_reg) + sum_t'(integ_reg)
                                               + sum_t'(d_reg), out_limit_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_reg        <= '0;
            integ_reg       <= '0;
            out_valid_reg   <= 1'b0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            time_step_reg   <= TIME_STEP_RESET;
            dead_band_reg   <= '0;
            integ_limit_reg <= LIMIT_RESET;
            out_limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_gain_reg   <= word_t'(cfg_data);
                    REG_INTEG_GAIN:  integ_gain_reg  <= word_t'(cfg_data);
                    REG_DERIV_GAIN:  deriv_gain_reg  <= word_t'(cfg_data);
                    REG_TIME_STEP:   time_step_reg   <= cfg_data[LIM_W-1:0];
                    REG_DEAD_BAND:   dead_band_reg   <= cfg_data[LIM_W-1:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIM_W-1:0];
                    REG_OUT_LIMIT:   out_limit_reg   <= cfg_data[LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        old_reg      <= old_next;
        diff_reg     <= diff_next;
        dead_reg     <= dead_next;
        neg_i_reg    <= neg_i_next;
        neg_p_reg    <= neg_p_next;
        neg_d_reg    <= neg_d_next;
        neg_t_reg    <= neg_t_next;
        t1_reg       <= t1_next;
        p_reg        <= p_next;
        t2_reg       <= t2_next;
        d_reg        <= d_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

>>> tb/ppid_checker.sv
// output checker for the positional pid block: tracks register writes, predicts
// drive and dead band flag for every input transfer and compares result transfers
// depends on ppid_pkg
module ppid_checker
    import ppid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [2*DATA_WIDTH-1:0] s_tdata,   // setpoint, measured
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [DATA_WIDTH-1:0]   m_tdata,   // drive
    input  logic                    m_tuser,   // in_deadband
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_WIDTH-1:0]   cfg_data,
    output int                      mismatches,
    output int                      outstanding,
    output int                      results_checked,
    output int                      deadband_hits
);

    typedef logic signed [127:0] big_t;

    typedef struct packed {
        word_t drive;
        logic  in_band;
    } outcome_t;

    word_t kp;
    word_t ki;
    word_t kd;
    ulim_t period;
    ulim_t band;
    ulim_t integ_lim;
    ulim_t out_lim;
    word_t last_error;
    word_t integ_acc;
    outcome_t due_outcomes[$];

    function automatic big_t saturate(input big_t v);
        if (v > big_t'(WORD_MAX))
            return big_t'(WORD_MAX);
        if (v < big_t'(WORD_MIN))
            return big_t'(WORD_MIN);
        return v;
    endfunction

    function automatic big_t clamp_to(input big_t v, input big_t lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // fixed-point product, floor toward minus infinity
    function automatic big_t fx_mul(input big_t a, input big_t b);
        return saturate((a * b) >>> FRAC_BITS);
    endfunction

    // floor(a*b/d), a zero divisor counts as one
    function automatic big_t fx_muldiv(input big_t a, input big_t b, input big_t d);
        big_t p;
        big_t q;
        big_t div;
        div = (d == 0) ? big_t'(1) : d;
        p = a * b;
        q = p / div;
        if (p < 0 && q * div != p)
            q = q - 1;
        return saturate(q);
    endfunction

    function automatic outcome_t pid_update(input word_t sp, input word_t pv);
        big_t err;
        big_t old;
        big_t acc;
        outcome_t r;
        err = saturate(big_t'(sp) - big_t'(pv));
        old = big_t'(last_error);
        last_error = word_t'(err);
        if ((err < 0 ? -err : err) <= big_t'(band))
        begin
            r.drive = '0;
            r.in_band = 1'b1;
            return r;
        end
        acc = big_t'(integ_acc) + fx_mul(fx_mul(big_t'(ki), err), big_t'(period));
        acc = clamp_to(acc, big_t'(integ_lim));
        integ_acc = word_t'(acc);
        acc = fx_mul(big_t'(kp), err) + acc + fx_muldiv(big_t'(kd), err - old, big_t'(period));
        r.drive = word_t'(clamp_to(acc, big_t'(out_lim)));
        r.in_band = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            kp = '0;
            ki = '0;
            kd = '0;
            period = TIME_STEP_RESET;
            band = '0;
            integ_lim = LIMIT_RESET;
            out_lim = LIMIT_RESET;
            last_error = '0;
            integ_acc = '0;
            due_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:   kp = word_t'(cfg_data);
                    REG_INTEG_GAIN:  ki = word_t'(cfg_data);
                    REG_DERIV_GAIN:  kd = word_t'(cfg_data);
                    REG_TIME_STEP:   period = cfg_data[LIM_W-1:0];
                    REG_DEAD_BAND:   band = cfg_data[LIM_W-1:0];
                    REG_INTEG_LIMIT: integ_lim = cfg_data[LIM_W-1:0];
                    REG_OUT_LIMIT:   out_lim = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            // result first: it can only belong to an earlier input transfer
            if (m_tvalid && m_tready)
            begin
                if (due_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: drive %0d flag %0b",
                                 $signed(m_tdata), m_tuser);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    results_checked <= results_checked + 1;
                    if (want.in_band)
                        deadband_hits <= deadband_hits + 1;
                    if (m_tdata !== want.drive || m_tuser !== want.in_band)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: drive exp %0d got %0d, dead band exp %0b got %0b",
                                     want.drive, $signed(m_tdata), want.in_band, m_tuser);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_outcomes.push_back(pid_update(word_t'(s_tdata[DATA_WIDTH-1:0]),
                                                  word_t'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH])));
            outstanding <= due_outcomes.size();
        end
    end

endmodule

>>> tb/testbench.sv
// top of the positional pid regression: clock, reset, register writes, input
// stream and output backpressure; ppid_checker predicts and compares the results
// depends on ppid_pkg, ppid_checker and positional_pid_antiwindup
module testbench;
    import ppid_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 136;
    localparam int SETTLE_CYCLES  = 120;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [2*DATA_WIDTH-1:0] s_tdata;   // setpoint, measured
    logic                    m_tvalid;
    logic                    m_tready;
    logic [DATA_WIDTH-1:0]   m_tdata;   // drive
    logic                    m_tuser;   // in_deadband
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DATA_WIDTH-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;
    int deadband_hits;
    int items_sent = 0;
    int settings_applied = 0;
    int hold_requests = 0;
    bit bursts_on = 1'b1;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    positional_pid_antiwindup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ppid_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .deadband_hits   (deadband_hits)
    );

    function automatic word_t near(input word_t base, input int unsigned span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - int'(span);
        return base + word_t'(off);
    endfunction

    function automatic word_t wild_word();
        case ($urandom_range(0, 5))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return word_t'(0);
            3:       return word_t'(-1);
            4:       return word_t'(1);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return wild_word();
            1:       return $urandom;
            default: return near(word_t'(0), 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_period();
        case ($urandom_range(0, 9))
            0:       return 32'd1;
            1:       return 32'h7fff_ffff;
            2:       return $urandom;
            default: return $urandom_range(32'h400, 32'h4_0000);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_band();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom;
            default: return $urandom_range(0, 32'h4000);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_limit();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return $urandom;
            2:       return 32'd0;
            default: return $urandom_range(32'h1_0000, 32'h400_0000);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [DATA_WIDTH-1:0] p, input logic [DATA_WIDTH-1:0] i,
                            input logic [DATA_WIDTH-1:0] d, input logic [DATA_WIDTH-1:0] ts,
                            input logic [DATA_WIDTH-1:0] db, input logic [DATA_WIDTH-1:0] il,
                            input logic [DATA_WIDTH-1:0] ol);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_INTEG_LIMIT, il);
        write_reg(REG_OUT_LIMIT, ol);
        settings_applied++;
    endtask

    task automatic send(input word_t sp, input word_t pv);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pv, sp};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_corners(input int n);
        for (int i = 0; i < n; i++)
        begin
            case (i)
                0:       send(WORD_MAX, WORD_MIN);
                1:       send(WORD_MIN, WORD_MAX);
                2:       send(word_t'(0), WORD_MIN);
                3:       send(WORD_MIN, word_t'(0));
                default: send(WORD_MAX, WORD_MAX);
            endcase
        end
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // register writes are only safe once the block has gone quiet
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output backpressure: random short stalls plus the requested long hold
    initial
    begin
        int stall_left;
        int hold_served;
        m_tready = 1'b0;
        stall_left = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        word_t sp;
        word_t pv;
        word_t target;
        int unsigned span;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero gains, so only the dead band flag moves
        send(word_t'(0), word_t'(0));
        send(word_t'(32'h1_0000), word_t'(0));

        settle();
        set_regs(32'h1_0000, 32'h8000, 32'h4000, 32'h1_0000, 32'h100,
                 32'h7fff_ffff, 32'h7fff_ffff);
        send_corners(5);
        send(word_t'(32'h100), word_t'(0));    // on the dead band edge
        send(word_t'(0), word_t'(32'h100));
        send(word_t'(0), word_t'(32'h101));    // just outside

        settle();
        set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0,
                 32'h7fff_ffff, 32'h7fff_ffff);
        send_corners(5);

        settle();
        set_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h0,
                 32'h0, 32'hffff_ffff);
        send_corners(5);

        // zero time step, and a write to an index past the register file
        settle();
        write_reg(REG_TIME_STEP, 32'h0);
        write_reg(REG_INTEG_LIMIT, 32'h7fff_ffff);
        write_reg(REG_OUT_LIMIT, 32'h100_0000);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        settings_applied++;
        send_corners(4);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            bursts_on = (ph < RANDOM_PHASES - 2);
            set_regs(rand_gain(), rand_gain(), rand_gain(), rand_period(), rand_band(),
                     rand_limit(), rand_limit());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, $urandom);
            case ($urandom_range(0, 3))
                0:       span = 32'h40;
                1:       span = 32'h2000;
                2:       span = 32'h4_0000;
                default: span = 32'h100_0000;
            endcase
            target = near(word_t'(0), 32'h100_0000);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 2 && k == 40)
                    hold_requests++;
                if (ph == 5 && k == 60)
                    wait_results();
                // mostly a loop tracking a setpoint, now and then a step or noise
                case ($urandom_range(0, 9))
                    7, 8:
                    begin
                        sp = word_t'($urandom);
                        pv = word_t'($urandom);
                    end
                    9:
                    begin
                        sp = wild_word();
                        pv = wild_word();
                    end
                    default:
                    begin
                        if ($urandom_range(0, 19) == 0)
                            target = near(word_t'(0), 32'h100_0000);
                        sp = target;
                        pv = near(target, span);
                    end
                endcase
                send(sp, pv);
            end
        end

        settle();
        $display("covered %0d items over %0d register settings, %0d results checked",
                 items_sent, settings_applied, results_checked);
        $display("%0d results in dead band, one long output stall and one full drain pause",
                 deadband_hits);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> positional_pid_antiwindup.f
src/ppid_pkg.sv
src/ppid_mul.sv
src/ppid_div.sv
src/positional_pid_antiwindup.sv
tb/ppid_checker.sv
tb/testbench.sv
